/* hdl/ppm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared widths, register indexes and defaults of the peak programme meter.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int ENV_W    = 15;
    localparam int COEF_W   = 16;
    localparam int NCH_W    = 4;
    localparam int PROD_W   = 32;

    // Stream packing
    localparam int S_TDATA_W = 24;  // sample, channel, pad
    localparam int M_TDATA_W = 32;  // level, block_max, pad

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CH  = 2'd2;

    localparam logic [NCH_W-1:0] NUM_CH_RESET = 4'd1;

    // Unity in Q0.16, one bit wider than a coefficient
    localparam logic [COEF_W:0] COEF_ONE = 17'h10000;

    localparam int MAX_CHANNELS_DEF = 8;

endpackage

/* hdl/ppm_env_calc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_env_calc
// Attack/release update of one envelope with a single shared multiplier.
// ----------------------------------------------------------------------------
module ppm_env_calc (
    input  logic signed [ppm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [ppm_pkg::ENV_W-1:0]    i_env,
    input  logic        [ppm_pkg::COEF_W-1:0]   i_attack,
    input  logic        [ppm_pkg::COEF_W-1:0]   i_release,
    output logic        [ppm_pkg::ENV_W-1:0]    o_env
);
    import ppm_pkg::*;

    logic                    decay;
    logic [SAMPLE_W-1:0]     diff;
    logic [ENV_W-1:0]        mul_a;
    logic [COEF_W:0]         mul_b;
    logic [PROD_W-1:0]       prod;
    logic [ENV_W-1:0]        prod_hi;

    // Sample below envelope selects decay, otherwise attack
    assign decay = i_sample < $signed({1'b0, i_env});
    assign diff  = i_sample - $signed({1'b0, i_env});

    // Operand select: decay env*(1-release), attack (x-env)*attack
    assign mul_a = decay ? i_env : diff[ENV_W-1:0];
    assign mul_b = decay ? (COEF_ONE - {1'b0, i_release}) : {1'b0, i_attack};

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_hi = prod[ENV_W+COEF_W-1:COEF_W];

    // Attack result never exceeds the sample, so no overflow past 15 bits
    assign o_env = decay ? prod_hi : i_env + prod_hi;

endmodule

/* hdl/peak_programme_meter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_programme_meter_unit
// Multichannel attack/release peak meter with a running block maximum.
// ----------------------------------------------------------------------------
// Result path: an accepted input is registered in the update stage, and its
//   result in the output register that drives the result stream.
// Throughput: one item per cycle unless the result stream stalls; envelope memory read
//   at accept, updated and written back as the update stage advances, same-channel forwarded.
// Reset: per-channel valid bits clear at once (envelopes read as zero),
//   running maximum zero, coefficients zero, channel count one. No clearing pass.
// ----------------------------------------------------------------------------
module peak_programme_meter_unit #(
    parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ppm_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,   // [15:0] sample, [18:16] channel
    input  logic                             i_s_axis_tuser,   // [0] block_start
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ppm_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,   // [14:0] level, [29:15] block_max
    output logic                             o_m_axis_tuser,   // [0] ignored
    // Configuration write
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ppm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ppm_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // Configuration registers
    logic [COEF_W-1:0] r_attack;
    logic [COEF_W-1:0] r_release;
    logic [NCH_W-1:0]  r_num_ch;

    // Envelope memory and per-entry valid bits
    logic [ENV_W-1:0]        mem_env [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_env_vld;

    // Input decode
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [CHAN_W-1:0]          in_chan;
    logic [AW-1:0]              rd_addr;
    logic                       in_ignore;
    logic                       in_accept;

    // Update stage
    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic [AW-1:0]              r_s1_addr;
    logic                       r_s1_start;
    logic                       r_s1_ignore;
    logic [ENV_W-1:0]           r_rd_data;
    logic                       r_rd_vld;
    logic                       r_fwd_hit;
    logic [ENV_W-1:0]           r_fwd_data;
    logic [ENV_W-1:0]           env_old;
    logic [ENV_W-1:0]           env_new;
    logic                       s1_adv;
    logic                       s1_write;

    // Running maximum
    logic [ENV_W-1:0] r_run_max;
    logic [ENV_W-1:0] max_base;
    logic [ENV_W-1:0] n_run_max;

    // Output register
    logic             r_out_valid;
    logic [ENV_W-1:0] r_out_level;
    logic [ENV_W-1:0] r_out_max;
    logic             r_out_ignore;
    logic             out_free;

    // Handshakes
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_adv          = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Input decode and channel range check
    assign in_sample = $signed(i_s_axis_tdata[SAMPLE_W-1:0]);
    assign in_chan   = i_s_axis_tdata[SAMPLE_W+CHAN_W-1:SAMPLE_W];
    assign rd_addr   = AW'(in_chan);
    assign in_ignore = ({1'b0, in_chan} >= r_num_ch) || (int'(in_chan) >= MAX_CHANNELS);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_release <= '0;
            r_num_ch  <= NUM_CH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ATTACK:  r_attack  <= i_cfg_data;
                REG_RELEASE: r_release <= i_cfg_data;
                REG_NUM_CH:  r_num_ch  <= i_cfg_data[NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Envelope memory: synchronous read at accept, write on update
    assign s1_write = s1_adv && !r_s1_ignore;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= mem_env[rd_addr];
        end
        if (s1_write) begin
            mem_env[r_s1_addr] <= env_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_vld <= '0;
        end else if (s1_write) begin
            r_env_vld[r_s1_addr] <= 1'b1;
        end
    end

    // Update stage capture, with forwarding of a same-edge write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_sample <= in_sample;
            r_s1_addr   <= rd_addr;
            r_s1_start  <= i_s_axis_tuser;
            r_s1_ignore <= in_ignore;
            r_rd_vld    <= r_env_vld[rd_addr];
            r_fwd_hit   <= s1_write && (r_s1_addr == rd_addr);
            r_fwd_data  <= env_new;
        end
    end

    assign env_old = r_fwd_hit ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

    ppm_env_calc u_calc (
        .i_sample  (r_s1_sample),
        .i_env     (env_old),
        .i_attack  (r_attack),
        .i_release (r_release),
        .o_env     (env_new)
    );

    // Running maximum, cleared by block start on active items
    assign max_base  = r_s1_start ? '0 : r_run_max;
    assign n_run_max = (env_new > max_base) ? env_new : max_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
        end else if (s1_write) begin
            r_run_max <= n_run_max;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_level  <= r_s1_ignore ? '0 : env_new;
            r_out_max    <= r_s1_ignore ? r_run_max : n_run_max;
            r_out_ignore <= r_s1_ignore;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - 2*ENV_W){1'b0}}, r_out_max, r_out_level};
    assign o_m_axis_tuser  = r_out_ignore;

    // Assertions
    a_ignored_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ignore |-> r_out_level == '0)
        else $error("ignored result carries nonzero level");

    a_level_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ignore |-> r_out_level <= r_out_max)
        else $error("level above block maximum");

    a_accept_frees_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && r_s1_valid |-> s1_adv)
        else $error("item accepted over a stalled update stage");

    a_max_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_write |=> $stable(r_run_max))
        else $error("running maximum moved without an update");

endmodule
